/* hdl/tsce_pkg.sv */
// Package for the text screen cursor engine: sizes, command codes,
// register indexes and the command, response and cell beat types.
// Used by text_screen_cursor_engine.
package tsce_pkg;

  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int STYLE_W = 16;
  localparam int CODE_W = 21;

  localparam logic [5:0] MAX_ROWS = 6'd32;
  localparam logic [7:0] MAX_COLUMNS = 8'd128;
  localparam logic [5:0] RESET_ROWS = 6'd24;
  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [CODE_W-1:0] BLANK_CODE = 21'h20;

  // Configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLUMNS = 1'b1;

  // Command codes
  localparam logic [3:0] REQ_PUT = 4'd0;
  localparam logic [3:0] REQ_PUT_STYLED = 4'd1;
  localparam logic [3:0] REQ_SET_STYLE = 4'd2;
  localparam logic [3:0] REQ_RESET_STYLE = 4'd3;
  localparam logic [3:0] REQ_MOVE_ABS = 4'd4;
  localparam logic [3:0] REQ_MOVE_REL = 4'd5;
  localparam logic [3:0] REQ_CR = 4'd6;
  localparam logic [3:0] REQ_LF = 4'd7;
  localparam logic [3:0] REQ_ERASE_LINE = 4'd8;
  localparam logic [3:0] REQ_ERASE_SCREEN = 4'd9;
  localparam logic [3:0] REQ_SCROLL = 4'd10;
  localparam logic [3:0] REQ_READ_CELL = 4'd11;
  localparam logic [3:0] REQ_CLEAR_DIRTY = 4'd12;

  // Erase modes
  localparam logic [1:0] ERASE_TO_END = 2'd0;
  localparam logic [1:0] ERASE_TO_START = 2'd1;
  localparam logic [1:0] ERASE_ALL = 2'd2;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [CODE_W-1:0]  char_code;
    logic [STYLE_W-1:0] style_word;
    logic [4:0]         target_row;
    logic [6:0]         target_column;
    logic signed [7:0]  delta_row;
    logic signed [7:0]  delta_column;
    logic [1:0]         erase_mode;
    logic signed [7:0]  scroll_count;
  } cmd_t;

  typedef struct packed {
    logic [4:0]         cursor_row;
    logic [7:0]         cursor_column;
    logic [CODE_W-1:0]  cell_code;
    logic [STYLE_W-1:0] cell_style;
    logic [31:0]        dirty_rows;
    logic               cursor_moved;
  } rsp_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [STYLE_W-1:0] style;
  } cell_t;

endpackage

/* hdl/text_screen_cursor_engine.sv */
// Top level of the text screen cursor engine: sequencer, cursor state and
// the 4096-entry cell memory. Depends on tsce_pkg.
//
// One command is taken when start is high and busy is low; its single
// response beat appears on rsp with done high for one cycle, and cannot be
// held off. After reset a clearing pass writes blanks to all 4096 cells,
// one a cycle, with busy high (register writes are still taken). Style,
// cursor, carriage return, line feed without scroll, dirty clear and
// unknown codes go straight to the done state; puts pass first through the
// cell write state and cell reads through the read state. Erases walk the
// cell memory write port one cell a cycle. Scrolls (and a line feed or put
// that scrolls at the bottom) copy each moved cell, read then write, over the
// single read and write port, then blank the freed rows one cell a cycle.
module text_screen_cursor_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tsce_pkg::cmd_t   cmd,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [7:0]       wr_data,
  output logic             done,
  output tsce_pkg::rsp_t   rsp
);
  import tsce_pkg::*;

  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PUTW  = 7'b0000100,
    S_COPY  = 7'b0001000,
    S_BLANK = 7'b0010000,
    S_RD    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [5:0]         rows_in_use;
  logic [7:0]         columns_in_use;
  logic [4:0]         cur_row;
  logic [7:0]         cur_col;
  logic [STYLE_W-1:0] cur_style;
  logic [31:0]        dirty_mask;
  logic               cursor_dirty;

  logic [ADDR_W-1:0]  clr_cnt;
  logic [4:0]         w_row;
  logic [4:0]         w_end;
  logic [7:0]         w_col;
  logic [7:0]         walk_le;
  logic               phase;
  logic [5:0]         k_reg;
  logic               up_reg;
  logic               put_after;
  logic [CODE_W-1:0]  put_code;
  logic [STYLE_W-1:0] put_style;
  logic [4:0]         trow_q;
  logic [6:0]         tcol_q;
  logic               rd_hit;

  cell_t              mem [4096];
  cell_t              rdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  cell_t              mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  // Effective sizes
  logic [5:0] rows_eff;
  logic [7:0] cols_eff;
  logic [4:0] rmax;
  logic [7:0] cmax;
  assign rows_eff = (rows_in_use == 6'd0) ? 6'd1 :
                    (rows_in_use > MAX_ROWS) ? MAX_ROWS : rows_in_use;
  assign cols_eff = (columns_in_use == 8'd0) ? 8'd1 :
                    (columns_in_use > MAX_COLUMNS) ? MAX_COLUMNS : columns_in_use;
  assign rmax = 5'(rows_eff - 6'd1);
  assign cmax = cols_eff - 8'd1;

  // Sizes as they stand after a register write, for the cursor clamp
  logic [5:0] new_rows_raw, new_rows_eff;
  logic [7:0] new_cols_raw, new_cols_eff;
  assign new_rows_raw = (wr_index == REG_ROWS) ? wr_data[5:0] : rows_in_use;
  assign new_cols_raw = (wr_index == REG_COLUMNS) ? wr_data : columns_in_use;
  assign new_rows_eff = (new_rows_raw == 6'd0) ? 6'd1 :
                        (new_rows_raw > MAX_ROWS) ? MAX_ROWS : new_rows_raw;
  assign new_cols_eff = (new_cols_raw == 8'd0) ? 8'd1 :
                        (new_cols_raw > MAX_COLUMNS) ? MAX_COLUMNS : new_cols_raw;

  // Mask of all active rows
  logic [31:0] all_rows;
  always_comb begin
    for (int i = 0; i < 32; i++) all_rows[i] = (6'(i) < rows_eff);
  end

  // Line-feed test and wrap-pending test
  logic at_bottom, wrap_pending;
  assign at_bottom = !(({1'b0, cur_row} + 6'd1) < rows_eff);
  assign wrap_pending = (cur_col >= cols_eff);

  // Scroll amount: the command's count, or one for a line feed at the bottom
  logic signed [7:0] sc_n;
  logic [7:0]        sc_abs;
  logic [5:0]        sc_k;
  logic              sc_up;
  assign sc_n = (cmd.req_type == REQ_SCROLL) ? cmd.scroll_count : 8'sd1;
  assign sc_up = !sc_n[7];
  assign sc_abs = sc_n[7] ? 8'(-sc_n) : 8'(sc_n);
  assign sc_k = (sc_abs > {2'b0, rows_eff}) ? rows_eff : sc_abs[5:0];

  // Relative move
  logic signed [9:0] rel_r, rel_c;
  logic [4:0] rel_row;
  logic [7:0] rel_col;
  assign rel_r = $signed({5'b0, cur_row}) + 10'(cmd.delta_row);
  assign rel_c = $signed({2'b0, cur_col}) + 10'(cmd.delta_column);
  always_comb begin
    if (rel_r < 0) rel_row = 5'd0;
    else if (!cmd.delta_row[7] && rel_r > $signed({5'b0, rmax})) rel_row = rmax;
    else rel_row = rel_r[4:0];
    if (rel_c < 0) rel_col = 8'd0;
    else if (!cmd.delta_column[7] && rel_c > $signed({2'b0, cmax})) rel_col = cmax;
    else rel_col = rel_c[7:0];
  end

  // End of the span blanked by an erase to start
  logic [7:0] start_end;
  assign start_end = wrap_pending ? cols_eff : cur_col + 8'd1;

  // Walk end column on the current row
  logic [7:0] walk_end;
  assign walk_end = (w_row == w_end) ? walk_le : cols_eff;

  // Source row of a copy
  logic [4:0] src_row;
  assign src_row = up_reg ? w_row + k_reg[4:0] : w_row - k_reg[4:0];

  // Cell memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = {w_row, w_col[COL_W-1:0]};
    mem_wdata = '{code: BLANK_CODE, style: cur_style};
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '{code: BLANK_CODE, style: '0};
      end
      S_PUTW: begin
        mem_we = 1'b1;
        mem_waddr = {cur_row, cur_col[COL_W-1:0]};
        mem_wdata = '{code: put_code, style: put_style};
      end
      S_COPY: begin
        mem_we = phase;
        mem_wdata = rdata;
      end
      S_BLANK: mem_we = (w_col < walk_end);
      default: mem_we = 1'b0;
    endcase
  end

  assign mem_raddr = (state == S_COPY) ? {src_row, w_col[COL_W-1:0]} : {trow_q, tcol_q};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // Sequencer and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      rows_in_use <= RESET_ROWS;
      columns_in_use <= RESET_COLUMNS;
      cur_row <= '0;
      cur_col <= '0;
      cur_style <= '0;
      dirty_mask <= '0;
      cursor_dirty <= 1'b0;
      rd_hit <= 1'b0;
      put_after <= 1'b0;
      phase <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) state <= S_IDLE;
        end

        S_IDLE: begin
          if (start) begin
            rd_hit <= 1'b0;
            put_after <= 1'b0;
            trow_q <= cmd.target_row;
            tcol_q <= cmd.target_column;
            state <= S_DONE;
            case (cmd.req_type)
              REQ_PUT, REQ_PUT_STYLED, REQ_LF: begin
                put_code <= cmd.char_code;
                put_style <= (cmd.req_type == REQ_PUT_STYLED) ? cmd.style_word : cur_style;
                if (cmd.req_type != REQ_LF && !wrap_pending) begin
                  state <= S_PUTW;
                end else begin
                  // Line feed, possibly with a one-row scroll
                  cursor_dirty <= 1'b1;
                  if (cmd.req_type != REQ_LF) cur_col <= '0;
                  if (!at_bottom) begin
                    cur_row <= cur_row + 5'd1;
                    if (cmd.req_type != REQ_LF) state <= S_PUTW;
                  end else begin
                    put_after <= (cmd.req_type != REQ_LF);
                    dirty_mask <= dirty_mask | all_rows;
                    k_reg <= 6'd1;
                    up_reg <= 1'b1;
                    phase <= 1'b0;
                    w_col <= '0;
                    walk_le <= cols_eff;
                    if (rows_eff > 6'd1) begin
                      w_row <= '0;
                      w_end <= 5'(rows_eff - 6'd2);
                      state <= S_COPY;
                    end else begin
                      w_row <= '0;
                      w_end <= rmax;
                      state <= S_BLANK;
                    end
                  end
                end
              end
              REQ_SET_STYLE: cur_style <= cmd.style_word;
              REQ_RESET_STYLE: cur_style <= '0;
              REQ_MOVE_ABS: begin
                cur_row <= ({1'b0, cmd.target_row} < rows_eff) ? cmd.target_row : rmax;
                cur_col <= ({1'b0, cmd.target_column} < cols_eff) ?
                           {1'b0, cmd.target_column} : cmax;
                cursor_dirty <= 1'b1;
              end
              REQ_MOVE_REL: begin
                cur_row <= rel_row;
                cur_col <= rel_col;
                cursor_dirty <= 1'b1;
              end
              REQ_CR: begin
                cur_col <= '0;
                cursor_dirty <= 1'b1;
              end
              REQ_ERASE_LINE, REQ_ERASE_SCREEN: begin
                w_col <= '0;
                w_row <= cur_row;
                w_end <= cur_row;
                walk_le <= cols_eff;
                if (cmd.erase_mode == ERASE_TO_END) begin
                  w_col <= cur_col;
                  if (cmd.req_type == REQ_ERASE_SCREEN) w_end <= rmax;
                  state <= S_BLANK;
                end else if (cmd.erase_mode == ERASE_TO_START) begin
                  walk_le <= start_end;
                  if (cmd.req_type == REQ_ERASE_SCREEN) w_row <= '0;
                  state <= S_BLANK;
                end else if (cmd.erase_mode == ERASE_ALL) begin
                  if (cmd.req_type == REQ_ERASE_SCREEN) begin
                    w_row <= '0;
                    w_end <= rmax;
                  end
                  state <= S_BLANK;
                end
              end
              REQ_SCROLL: begin
                if (sc_n != 8'sd0) begin
                  dirty_mask <= dirty_mask | all_rows;
                  k_reg <= sc_k;
                  up_reg <= sc_up;
                  phase <= 1'b0;
                  w_col <= '0;
                  walk_le <= cols_eff;
                  if (sc_k < rows_eff) begin
                    w_row <= sc_up ? 5'd0 : rmax;
                    w_end <= sc_up ? 5'(rows_eff - sc_k - 6'd1) : sc_k[4:0];
                    state <= S_COPY;
                  end else begin
                    w_row <= '0;
                    w_end <= rmax;
                    state <= S_BLANK;
                  end
                end
              end
              REQ_READ_CELL: begin
                rd_hit <= ({1'b0, cmd.target_row} < rows_eff) &&
                          ({1'b0, cmd.target_column} < cols_eff);
                state <= S_RD;
              end
              REQ_CLEAR_DIRTY: begin
                dirty_mask <= '0;
                cursor_dirty <= 1'b0;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // Read a source cell, then write it to the destination row
        S_COPY: begin
          phase <= !phase;
          if (phase) begin
            if (w_col + 8'd1 >= cols_eff) begin
              w_col <= '0;
              if (w_row == w_end) begin
                w_row <= up_reg ? 5'(rows_eff - k_reg) : 5'd0;
                w_end <= up_reg ? rmax : 5'(k_reg - 6'd1);
                walk_le <= cols_eff;
                state <= S_BLANK;
              end else begin
                w_row <= up_reg ? w_row + 5'd1 : w_row - 5'd1;
              end
            end else begin
              w_col <= w_col + 8'd1;
            end
          end
        end

        // Blank one cell a cycle; mark each visited row
        S_BLANK: begin
          dirty_mask[w_row] <= 1'b1;
          if (w_col < walk_end) begin
            w_col <= w_col + 8'd1;
          end else if (w_row == w_end) begin
            state <= put_after ? S_PUTW : S_DONE;
          end else begin
            w_row <= w_row + 5'd1;
            w_col <= '0;
          end
        end

        S_PUTW: begin
          dirty_mask[cur_row] <= 1'b1;
          cur_col <= cur_col + 8'd1;
          cursor_dirty <= 1'b1;
          state <= S_DONE;
        end

        S_RD: state <= S_DONE;

        S_DONE: state <= S_IDLE;

        default: state <= S_IDLE;
      endcase

      // Register write; clamp the cursor to the new area
      if (wr_en) begin
        if (wr_index == REG_ROWS) rows_in_use <= wr_data[5:0];
        else columns_in_use <= wr_data;
        if ({1'b0, cur_row} > new_rows_eff - 6'd1) cur_row <= 5'(new_rows_eff - 6'd1);
        if (cur_col > new_cols_eff) cur_col <= new_cols_eff;
      end
    end
  end

  // Response beat
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign rsp.cursor_row = cur_row;
  assign rsp.cursor_column = cur_col;
  assign rsp.cell_code = rd_hit ? rdata.code : '0;
  assign rsp.cell_style = rd_hit ? rdata.style : '0;
  assign rsp.dirty_rows = dirty_mask;
  assign rsp.cursor_moved = cursor_dirty;

endmodule
